@@ design/sobel_gradient_3x3_assert.svh @@
// Assertion macros shared by the checker of the Sobel gradient block.
// Needs a clk and an rst_n in the scope where the macros are used.
`ifndef SOBEL_GRADIENT_3X3_ASSERT_SVH
`define SOBEL_GRADIENT_3X3_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SGR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define SGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define SGR_ASSERT_NEXT_ANY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/sgr_pkg.sv @@
// Types and constants shared by the Sobel gradient block.
// No dependencies.
package sgr_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 11;
  localparam int ROW_W      = 16;
  localparam int CFG_W      = 16;
  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 11;
  localparam int OUT_DATA_W = 56;
  localparam int LINE_W     = 2 * PIX_W;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [WIDTH_W-1:0] WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [ROW_W-1:0]   HEIGHT_RESET = ROW_W'(480);

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pixel_t;

  // Window indexed [row][col]; row 2 is the newest row, col 2 the newest column.
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  // One input pixel's worth of work for the back end. Mask bits, in output
  // order: row above/col left, row above/this col, this row/col left,
  // this row/this col.
  typedef struct packed {
    win_t             win;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [3:0]       mask;
  } job_t;

endpackage

@@ design/sgr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read returns the old contents on a same-address write.
module sgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/sgr_front.sv @@
// Front end: accepts pixels, tracks position, keeps the line store and window,
// and classifies which results each pixel releases. Uses sgr_pkg and sgr_ram.
module sgr_front
  import sgr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  pixel_t           pixel,
  input  logic [COL_W-1:0] last_col,
  input  logic [ROW_W-1:0] last_row,
  output logic             busy,
  output logic             push,
  output job_t             push_job
);

  logic [COL_W-1:0] col_r, col_nxt, cur_col;
  logic [ROW_W-1:0] row_r, row_nxt, cur_row;

  logic             b_valid_r;
  pixel_t           b_px_r;
  logic [COL_W-1:0] b_col_r;
  logic [ROW_W-1:0] b_row_r;
  logic             b_col_last_r, b_row_last_r;
  logic             bypass_r;
  logic [LINE_W-1:0] fwd_r;

  logic [LINE_W-1:0] ram_q, line_rd, line_wr;
  win_t             win_r, win_nxt;
  logic [3:0]       mask;
  logic             has_up, has_left;

  // A counter left beyond a shrunken frame counts as the last column or row.
  assign cur_col = (col_r > last_col) ? last_col : col_r;
  assign cur_row = (row_r > last_row) ? last_row : row_r;

  always_comb begin
    if (cur_col == last_col) begin
      col_nxt = '0;
      row_nxt = (cur_row == last_row) ? '0 : cur_row + ROW_W'(1);
    end else begin
      col_nxt = cur_col + COL_W'(1);
      row_nxt = cur_row;
    end
  end

  // Each word holds {older line, newer line} for one column.
  sgr_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (b_valid_r),
    .waddr (b_col_r),
    .wdata (line_wr),
    .re    (accept),
    .raddr (cur_col),
    .rdata (ram_q)
  );

  // A one-column frame reads the word that the previous pixel writes in the
  // same cycle, so that word is forwarded around the memory.
  assign line_rd = bypass_r ? fwd_r : ram_q;
  assign line_wr = {line_rd[PIX_W-1:0], b_px_r};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = line_rd[LINE_W-1:PIX_W];
    win_nxt[1][2] = line_rd[PIX_W-1:0];
    win_nxt[2][2] = b_px_r;
  end

  assign has_up   = (b_row_r != '0);
  assign has_left = (b_col_r != '0);
  assign mask = {b_row_last_r & b_col_last_r, b_row_last_r & has_left,
                 has_up & b_col_last_r, has_up & has_left};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      b_valid_r <= 1'b0;
      bypass_r  <= 1'b0;
      win_r     <= '0;
    end else begin
      b_valid_r <= accept;
      if (accept) begin
        col_r    <= col_nxt;
        row_r    <= row_nxt;
        bypass_r <= b_valid_r && (b_col_r == cur_col);
      end
      if (b_valid_r) begin
        win_r <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_px_r       <= pixel;
      b_col_r      <= cur_col;
      b_row_r      <= cur_row;
      b_col_last_r <= (cur_col == last_col);
      b_row_last_r <= (cur_row == last_row);
      fwd_r        <= line_wr;
    end
  end

  assign busy          = b_valid_r;
  assign push          = b_valid_r && (mask != '0);
  assign push_job.win  = win_nxt;
  assign push_job.col  = b_col_r;
  assign push_job.row  = b_row_r;
  assign push_job.mask = mask;

endmodule

@@ design/sgr_queue.sv @@
// Short job queue between the front end and the back end.
// Uses sgr_pkg for the job type and depth.
module sgr_queue
  import sgr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  job_t              push_job,
  input  logic              pop,
  output logic              head_valid,
  output job_t              head_job,
  output logic [QCNT_W-1:0] count
);

  job_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_pop;

  assign do_pop = pop && (count_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  assign head_valid = (count_r != '0);
  assign head_job   = entry_r[rd_ptr_r];
  assign count      = count_r;

endmodule

@@ design/sgr_back.sv @@
// Back end: expands each job into its results, computes the Sobel gradients
// and holds the output register. Uses sgr_pkg.
module sgr_back
  import sgr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  job_t                  head_job,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  output logic                  out_tuser
);

  logic [3:0] done_r, remain, sel;
  logic       load, last_sel, row_sel, col_sel;
  logic [1:0] top, mid, bot, lft, ctr, rgt;
  logic signed [GRAD_W:0] ul, uc, ur, ml, mr, dl, dc, dr, gx, gy;
  logic [COL_W-1:0] x;
  logic [ROW_W-1:0] y;

  logic                  valid_r;
  logic [OUT_DATA_W-1:0] data_r;
  logic                  last_r, frame_end_r;

  assign remain = head_job.mask & ~done_r;

  always_comb begin
    sel = '0;
    priority if (remain[0]) sel[0] = 1'b1;
    else if (remain[1])     sel[1] = 1'b1;
    else if (remain[2])     sel[2] = 1'b1;
    else                    sel[3] = 1'b1;
  end

  assign last_sel = (remain & ~sel) == '0;
  assign row_sel  = sel[2] | sel[3];
  assign col_sel  = sel[1] | sel[3];

  // Missing neighbors at the borders replicate the center row or column.
  always_comb begin
    if (row_sel) begin
      mid = 2'd2;
      bot = 2'd2;
      top = (head_job.row == '0) ? 2'd2 : 2'd1;
      y   = head_job.row;
    end else begin
      mid = 2'd1;
      bot = 2'd2;
      top = (head_job.row == ROW_W'(1)) ? 2'd1 : 2'd0;
      y   = head_job.row - ROW_W'(1);
    end
    if (col_sel) begin
      ctr = 2'd2;
      rgt = 2'd2;
      lft = (head_job.col == '0) ? 2'd2 : 2'd1;
      x   = head_job.col;
    end else begin
      ctr = 2'd1;
      rgt = 2'd2;
      lft = (head_job.col == COL_W'(1)) ? 2'd1 : 2'd0;
      x   = head_job.col - COL_W'(1);
    end
  end

  assign ul = $signed({4'b0, head_job.win[top][lft]});
  assign uc = $signed({4'b0, head_job.win[top][ctr]});
  assign ur = $signed({4'b0, head_job.win[top][rgt]});
  assign ml = $signed({4'b0, head_job.win[mid][lft]});
  assign mr = $signed({4'b0, head_job.win[mid][rgt]});
  assign dl = $signed({4'b0, head_job.win[bot][lft]});
  assign dc = $signed({4'b0, head_job.win[bot][ctr]});
  assign dr = $signed({4'b0, head_job.win[bot][rgt]});

  assign gx = ((mr - ml) <<< 1) + (ur - ul) + (dr - dl);
  assign gy = ((dc - uc) <<< 1) + (dl - ul) + (dr - ur);

  assign load = head_valid && (!valid_r || out_tready);
  assign pop  = load && last_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      done_r  <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        done_r  <= last_sel ? '0 : (done_r | sel);
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r      <= {y, x, gy[GRAD_W-1:0], gx[GRAD_W-1:0], head_job.win[mid][ctr]};
      last_r      <= last_sel;
      frame_end_r <= row_sel & col_sel;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = frame_end_r;
  assign out_tuser  = last_r;

endmodule

@@ design/sobel_gradient_3x3.sv @@
// Sobel gradient block: 3x3 Sobel over a raster pixel stream, borders replicated.
// Throughput: one pixel per clock while in_tready is high; results at one per clock
// while out_tready is high, so the last row, where pixels after the first release two
// results each (four for the bottom right), runs at half rate.
// Reset: rst_n (synchronous) clears counters, window, queue and output valid;
// the line store is not cleared and needs no clearing pass.
module sobel_gradient_3x3
  import sgr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // [7:0] pixel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] gray_level, [18:8] grad_x, [29:19] grad_y, [39:30] out_col,
  // [55:40] out_row
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,  // last_of_frame
  output logic                  out_tuser,  // [0] last_of_item
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  logic [WIDTH_W-1:0] width_r;
  logic [ROW_W-1:0]   height_r;
  logic [COL_W-1:0]   last_col;
  logic [ROW_W-1:0]   last_row;

  logic              accept, busy, push, pop, head_valid;
  job_t              push_job, head_job;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W:0]   used;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Width zero acts as one column; widths above the line store are clipped.
  always_comb begin
    if (width_r == '0) begin
      last_col = '0;
    end else if (width_r >= WIDTH_W'(MAX_WIDTH)) begin
      last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_W'(width_r - WIDTH_W'(1));
    end
    last_row = (height_r == '0) ? '0 : height_r - ROW_W'(1);
  end

  // Room is held for the pixel in flight and the one taken now, since a
  // classified job enters the queue without waiting.
  assign used      = {1'b0, q_count} + (QCNT_W + 1)'(busy);
  assign in_tready = used < (QCNT_W + 1)'(QDEPTH - 1);
  assign accept    = in_tvalid && in_tready;

  sgr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .pixel    (in_tdata),
    .last_col (last_col),
    .last_row (last_row),
    .busy     (busy),
    .push     (push),
    .push_job (push_job)
  );

  sgr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job),
    .count      (q_count)
  );

  sgr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

@@ design/sgr_checker.sv @@
// Port-level checker for the Sobel gradient block, bound to the top level.
// Uses sgr_pkg and the macros in sobel_gradient_3x3_assert.svh.
`include "sobel_gradient_3x3_assert.svh"

module sgr_checker
  import sgr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast,
  input logic                  out_tuser
);

  // A stalled result keeps its payload.
  `SGR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser),
    "stalled result changed")

  // The bottom right result is always the last one released by its pixel.
  `SGR_ASSERT_NOW(a_frame_end_closes_item, out_tvalid && out_tlast, out_tuser,
    "frame end result is not the last of its pixel")

  // The results of one pixel leave back to back, without a gap.
  `SGR_ASSERT_NEXT(a_item_contiguous, out_tvalid && out_tready && !out_tuser,
    out_tvalid, "gap inside the results of one pixel")

  // Reset empties the output.
  `SGR_ASSERT_NEXT_ANY(a_reset_clears, !rst_n, !out_tvalid,
    "result offered right after reset")

endmodule

bind sobel_gradient_3x3 sgr_checker u_checker (.*);
